@@ src/battery_level_notch_estimator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the notch estimator checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_NOTCH_ESTIMATOR_CORE_DEFINES_SVH
`define BATTERY_LEVEL_NOTCH_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define BLNE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blne check failed");

// next-cycle implication, masked during reset
`define BLNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blne check failed");

`endif

@@ src/blne_pkg.sv @@
// ----------------------------------------------------------------------------
// blne_pkg
// Types, constants and notch helpers for the battery notch estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blne_pkg;

  localparam int SAMPLES_PER_GROUP_DEF = 5;
  localparam int SAMPLE_BITS_DEF       = 13;
  localparam int QUEUE_DEPTH           = 4;

  localparam int CFG_MV_BITS    = 13;
  localparam int CFG_HYST_BITS  = 8;
  localparam int CFG_COUNT_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  localparam int LEVEL_BITS     = 7;
  localparam int MEDIAN_BITS    = 13;
  localparam int OUT_TDATA_BITS = 24;
  localparam int NOTCH_BITS     = 4;
  // widest biased voltage: 16-bit sample plus hysteresis
  localparam int NOTCH_IN_BITS  = 17;
  localparam int NOTCH_COUNT    = 11;
  localparam int LEVEL_STEP     = 10;

  localparam logic [CFG_MV_BITS-1:0]    MIN_VALID_MV_RST    = 13'd2500;
  localparam logic [CFG_MV_BITS-1:0]    MAX_VALID_MV_RST    = 13'd4500;
  localparam logic [CFG_HYST_BITS-1:0]  HYSTERESIS_MV_RST   = 8'd8;
  localparam logic [CFG_COUNT_BITS-1:0] MIN_VALID_COUNT_RST = 3'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIN_VALID_MV    = 2'd0,
    CFG_MAX_VALID_MV    = 2'd1,
    CFG_HYSTERESIS_MV   = 2'd2,
    CFG_MIN_VALID_COUNT = 2'd3
  } cfg_index_t;

  localparam logic [15:0] NOTCH_MV [NOTCH_COUNT] = '{
    16'd3450, 16'd3680, 16'd3740, 16'd3770, 16'd3790, 16'd3820,
    16'd3870, 16'd3920, 16'd3980, 16'd4060, 16'd4200
  };

  typedef struct packed {
    logic [CFG_MV_BITS-1:0]    min_valid_mv;
    logic [CFG_MV_BITS-1:0]    max_valid_mv;
    logic [CFG_HYST_BITS-1:0]  hysteresis_mv;
    logic [CFG_COUNT_BITS-1:0] min_valid_count;
  } blne_cfg_t;

  // classification that travels with each queued sample
  typedef struct packed {
    logic valid;
    logic last;
  } blne_tag_t;

  typedef enum logic [2:0] {
    BK_COLLECT,
    BK_EVAL,
    BK_NOTCH,
    BK_HYST,
    BK_OUT
  } back_state_t;

  // notch index = number of midpoints at or below mv
  function automatic logic [NOTCH_BITS-1:0] notch_of(input logic [NOTCH_IN_BITS-1:0] mv);
    logic [NOTCH_BITS-1:0] idx;
    logic [16:0]           mid;
    idx = '0;
    for (int i = 1; i < NOTCH_COUNT; i++) begin
      mid = ({1'b0, NOTCH_MV[i-1]} + {1'b0, NOTCH_MV[i]}) >> 1;
      if (mv >= NOTCH_IN_BITS'(mid)) idx = NOTCH_BITS'(i);
    end
    return idx;
  endfunction

  function automatic logic [LEVEL_BITS-1:0] percent_of(input logic [NOTCH_BITS-1:0] idx);
    return LEVEL_BITS'(idx * LEVEL_STEP);
  endfunction

endpackage

@@ src/blne_front.sv @@
// ----------------------------------------------------------------------------
// blne_front
// Accepts samples, checks them against the window and marks group ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blne_front #(
  parameter int SAMPLES_PER_GROUP = blne_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int SAMPLE_BITS       = blne_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  blne_pkg::blne_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_mv,
  input  logic                   q_ready,
  output logic                   q_push,
  output logic [SAMPLE_BITS-1:0] q_mv,
  output blne_pkg::blne_tag_t    q_tag
);
  import blne_pkg::*;

  localparam int GW   = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam int CMPW = (SAMPLE_BITS > CFG_MV_BITS) ? SAMPLE_BITS : CFG_MV_BITS;

  logic [GW-1:0] group_index;
  logic [GW-1:0] group_index_next;
  logic          last;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;
  assign q_mv     = in_mv;
  assign last     = (group_index == GW'(SAMPLES_PER_GROUP - 1));

  always_comb begin
    q_tag.valid = (CMPW'(in_mv) >= CMPW'(cfg.min_valid_mv)) &&
                  (CMPW'(in_mv) <= CMPW'(cfg.max_valid_mv));
    q_tag.last  = last;
  end

  assign group_index_next = last ? '0 : group_index + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_index <= '0;
    end else if (q_push) begin
      group_index <= group_index_next;
    end
  end

endmodule

@@ src/blne_queue.sv @@
// ----------------------------------------------------------------------------
// blne_queue
// Small FIFO between the classify front and the evaluate back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blne_queue #(
  parameter int WIDTH = 15,
  parameter int DEPTH = blne_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import blne_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

@@ src/blne_back.sv @@
// ----------------------------------------------------------------------------
// blne_back
// Sorted insertion of valid samples, median pick, notch map with hysteresis
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blne_back #(
  parameter int SAMPLES_PER_GROUP = blne_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int SAMPLE_BITS       = blne_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  blne_pkg::blne_cfg_t                  cfg,
  input  logic                                 q_valid,
  input  logic [SAMPLE_BITS-1:0]               q_mv,
  input  blne_pkg::blne_tag_t                  q_tag,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [blne_pkg::LEVEL_BITS-1:0]      out_level,
  output logic                                 out_ok,
  output logic [blne_pkg::MEDIAN_BITS-1:0]     out_median
);
  import blne_pkg::*;

  localparam int N  = SAMPLES_PER_GROUP;
  localparam int CW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int NW = (CW > CFG_COUNT_BITS) ? CW : CFG_COUNT_BITS;
  localparam int BW = SAMPLE_BITS + 1;

  back_state_t state;
  back_state_t state_next;

  logic [SAMPLE_BITS-1:0] sorted     [N];
  logic [SAMPLE_BITS-1:0] sorted_next[N];
  logic [N-1:0]           gt;
  logic [CW-1:0]          cnt;
  logic [CFG_COUNT_BITS-1:0] need;

  logic                   ok_r;
  logic [SAMPLE_BITS-1:0] med_r;
  logic [NOTCH_BITS-1:0]  notch_now;
  logic [NOTCH_BITS-1:0]  notch_r;
  logic [BW-1:0]          biased_r;
  logic [NOTCH_BITS-1:0]  final_idx;
  logic [NOTCH_BITS-1:0]  cache_idx;
  logic                   have_reading;

  // insertion point: every cell past the fill or above the new value moves up
  always_comb begin
    for (int k = 0; k < N; k++) begin
      gt[k] = (CW'(k) >= cnt) || (sorted[k] > q_mv);
    end
    for (int k = 0; k < N; k++) begin
      if (!gt[k]) sorted_next[k] = sorted[k];
      else if (k == 0) sorted_next[k] = q_mv;
      else if (!gt[k-1]) sorted_next[k] = q_mv;
      else sorted_next[k] = sorted[k-1];
    end
  end

  assign need      = (cfg.min_valid_count == '0) ? CFG_COUNT_BITS'(1) : cfg.min_valid_count;
  assign notch_now = notch_of(NOTCH_IN_BITS'(med_r));
  assign final_idx = (!have_reading || notch_r == cache_idx ||
                      notch_of(NOTCH_IN_BITS'(biased_r)) == notch_r) ? notch_r : cache_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_COLLECT: if (q_valid && q_tag.last) state_next = BK_EVAL;
      BK_EVAL:    state_next = BK_NOTCH;
      BK_NOTCH:   state_next = BK_HYST;
      BK_HYST:    state_next = BK_OUT;
      BK_OUT:     if (out_ready) state_next = BK_COLLECT;
      default:    state_next = BK_COLLECT;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      BK_COLLECT: q_pop = q_valid;
      BK_OUT:     out_valid = 1'b1;
      default: begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_tag.valid) sorted <= sorted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_COLLECT;
      cnt          <= '0;
      cache_idx    <= '0;
      have_reading <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_tag.valid) cnt <= cnt + 1'b1;
      if (state == BK_EVAL) cnt <= '0;
      if (state == BK_HYST && ok_r) begin
        cache_idx    <= final_idx;
        have_reading <= 1'b1;
      end
    end
  end

  // datapath stages for the EVAL, NOTCH and HYST sequencer steps
  always_ff @(posedge clk) begin
    unique case (state)
      BK_EVAL: begin
        ok_r  <= NW'(cnt) >= NW'(need);
        med_r <= sorted[IW'(cnt >> 1)];
      end
      BK_NOTCH: begin
        notch_r <= notch_now;
        if (notch_now > cache_idx) begin
          biased_r <= (BW'(med_r) > BW'(cfg.hysteresis_mv)) ?
                      BW'(med_r) - BW'(cfg.hysteresis_mv) : '0;
        end else begin
          biased_r <= BW'(med_r) + BW'(cfg.hysteresis_mv);
        end
      end
      BK_HYST: begin
        out_ok <= ok_r;
        if (ok_r) begin
          out_level  <= percent_of(final_idx);
          out_median <= MEDIAN_BITS'(med_r);
        end else begin
          out_level  <= have_reading ? percent_of(cache_idx) : '0;
          out_median <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/battery_level_notch_estimator_core.sv @@
// ----------------------------------------------------------------------------
// battery_level_notch_estimator_core
// Median of the in-window samples of each group, mapped to a ten percent
// notch with hysteresis against notch changes.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    tdata: sample_mv
//   m_*       out  m_tvalid/m_tready    tdata: level_percent, median_mv
//                                       tuser: reading_ok
//   cfg_*     in   cfg_we               cfg_index, cfg_data
//
// The front takes one word per cycle while its 4-entry queue has room.
// While collecting, the back drains one queued sample per cycle, inserting
// in-window ones into a sorted row, then steps through median, notch and hysteresis.
// A waiting result stalls only the back; the front keeps filling the queue.
// rst is synchronous: clears counters, queue, cache and state, reloads config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_level_notch_estimator_core #(
  parameter int SAMPLES_PER_GROUP = blne_pkg::SAMPLES_PER_GROUP_DEF,
  parameter int SAMPLE_BITS       = blne_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // sample_mv
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // level_percent, median_mv
  output logic [blne_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  // reading_ok
  output logic [0:0]                            m_tuser,
  input  logic                                  cfg_we,
  input  logic [blne_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [blne_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import blne_pkg::*;

  localparam int QW = SAMPLE_BITS + $bits(blne_tag_t);

  blne_cfg_t              cfg;
  logic                   q_ready;
  logic                   q_push;
  logic [SAMPLE_BITS-1:0] f_mv;
  blne_tag_t              f_tag;
  logic                   q_valid;
  logic                   q_pop;
  logic [QW-1:0]          q_out;
  logic [SAMPLE_BITS-1:0] b_mv;
  blne_tag_t              b_tag;
  logic [LEVEL_BITS-1:0]  level;
  logic                   ok;
  logic [MEDIAN_BITS-1:0] median;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid_mv    <= MIN_VALID_MV_RST;
      cfg.max_valid_mv    <= MAX_VALID_MV_RST;
      cfg.hysteresis_mv   <= HYSTERESIS_MV_RST;
      cfg.min_valid_count <= MIN_VALID_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_VALID_MV:    cfg.min_valid_mv    <= cfg_data;
        CFG_MAX_VALID_MV:    cfg.max_valid_mv    <= cfg_data;
        CFG_HYSTERESIS_MV:   cfg.hysteresis_mv   <= cfg_data[CFG_HYST_BITS-1:0];
        CFG_MIN_VALID_COUNT: cfg.min_valid_count <= cfg_data[CFG_COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  blne_front #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_mv   (s_tdata[SAMPLE_BITS-1:0]),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_mv    (f_mv),
    .q_tag   (f_tag)
  );

  blne_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_tag, f_mv}),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  assign b_mv  = q_out[SAMPLE_BITS-1:0];
  assign b_tag = blne_tag_t'(q_out[QW-1:SAMPLE_BITS]);

  blne_back #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_mv      (b_mv),
    .q_tag     (b_tag),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_level (level),
    .out_ok    (ok),
    .out_median(median)
  );

  assign m_tdata = {(OUT_TDATA_BITS - MEDIAN_BITS - LEVEL_BITS)'(0), median, level};
  assign m_tuser = ok;

endmodule

@@ src/blne_checker.sv @@
// ----------------------------------------------------------------------------
// blne_checker
// Port-level checks on the result channel of the notch estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_level_notch_estimator_core_defines.svh"

module blne_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [blne_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic [0:0]                          m_tuser
);
  import blne_pkg::*;

  logic seen_ok;

  // set once a good reading has been handed out
  always_ff @(posedge clk) begin
    if (rst) seen_ok <= 1'b0;
    else if (m_tvalid && m_tready && m_tuser[0]) seen_ok <= 1'b1;
  end

  `BLNE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `BLNE_ASSERT_SAME(a_median_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[19:7] == 13'd0)
  `BLNE_ASSERT_SAME(a_no_cache_zero, clk, rst, m_tvalid && !m_tuser[0] && !seen_ok, m_tdata[6:0] == 7'd0)

endmodule

bind battery_level_notch_estimator_core blne_checker u_blne_checker (.*);
